/* rtl/rational_arithmetic_unit_top_assert.svh */
// Assertion macros for the rational arithmetic unit.
`ifndef RATIONAL_ARITHMETIC_UNIT_TOP_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define RAU_ASSERT_IMP(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("assertion failed");
// Implication checked in the cycle after the antecedent.
`define RAU_ASSERT_NEXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

/* rtl/rau_pkg.sv */
// Package with payload types, codes and sequencer states for the rational unit.
package rau_pkg;
	typedef enum logic [1:0] {OP_ADD = 2'd0, OP_SUB = 2'd1, OP_MUL = 2'd2, OP_DIV = 2'd3} op_t;
	typedef enum logic [1:0] {ST_OK = 2'd0, ST_INF = 2'd1, ST_INVALID = 2'd2} status_t;

	typedef struct packed {
		logic [1:0] operation;
		logic signed [31:0] a_num;
		logic signed [31:0] a_den;
		logic signed [31:0] b_num;
		logic signed [31:0] b_den;
	} in_word_t;

	typedef struct packed {
		logic signed [63:0] result_num;
		logic [62:0] result_den;
		logic [1:0] status;
		logic [62:0] whole_part;
		logic [61:0] remainder;
		logic negative;
	} out_word_t;

	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_RED_A, S_RED_B, S_MUL1, S_MUL2, S_MUL3, S_COMBINE,
		S_RED_R, S_SPLIT, S_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic [63:0] a;
		logic [63:0] b;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [63:0] quo;
		logic [63:0] rem;
	} div_rsp_t;
endpackage

/* rtl/rau_divider.sv */
// Shared restoring divider, one quotient bit per cycle, 64-bit unsigned.
module rau_divider import rau_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	logic [63:0] quo_q, rem_q, den_q;
	logic [6:0] cnt_q;
	logic busy_q, done_q;
	logic [64:0] trial;

	assign trial = {rem_q, quo_q[63]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.a;
			den_q <= req.b;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[62:0], quo_q[63]};
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo = quo_q;
	assign rsp.rem = rem_q;
endmodule

/* rtl/rau_reducer.sv */
// Reduces a fraction: Euclidean gcd then both parts divided by it, using the shared divider.
module rau_reducer import rau_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num_mag,
	input  logic [63:0] den,
	input  div_rsp_t    rsp,
	output div_req_t    req,
	output logic        done,
	output logic [63:0] num_out,
	output logic [63:0] den_out
);
	typedef enum logic [2:0] {R_IDLE, R_GCD, R_WAIT_G, R_DIV_N, R_DIV_D, R_DONE} rstate_t;
	rstate_t rs_q;
	logic [63:0] p_q, q_q, g_q, n_q, d_q;
	logic issue_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rs_q <= R_IDLE;
			issue_q <= 1'b0;
		end else begin
			issue_q <= 1'b0;
			case (rs_q)
				R_IDLE: if (start) rs_q <= R_GCD;
				R_GCD: begin
					if (q_q == '0) begin
						rs_q <= R_DIV_N;
						issue_q <= 1'b1;
					end else begin
						rs_q <= R_WAIT_G;
						issue_q <= 1'b1;
					end
				end
				R_WAIT_G: if (rsp.done) rs_q <= R_GCD;
				R_DIV_N: if (rsp.done) begin
					rs_q <= R_DIV_D;
					issue_q <= 1'b1;
				end
				R_DIV_D: if (rsp.done) rs_q <= R_DONE;
				R_DONE: rs_q <= R_IDLE;
				default: rs_q <= R_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (rs_q)
			R_IDLE: if (start) begin
				p_q <= num_mag;
				q_q <= den;
				n_q <= num_mag;
				d_q <= den;
			end
			R_GCD: if (q_q == '0) g_q <= (p_q == '0) ? 64'd1 : p_q;
			R_WAIT_G: if (rsp.done) begin
				p_q <= q_q;
				q_q <= rsp.rem;
			end
			R_DIV_N: if (rsp.done) n_q <= rsp.quo;
			R_DIV_D: if (rsp.done) d_q <= rsp.quo;
			default: ;
		endcase
	end

	always_comb begin
		req.start = issue_q;
		req.a = p_q;
		req.b = q_q;
		if (rs_q == R_DIV_N) begin
			req.a = n_q;
			req.b = g_q;
		end else if (rs_q == R_DIV_D) begin
			req.a = d_q;
			req.b = g_q;
		end
	end

	assign done = (rs_q == R_DONE);
	assign num_out = n_q;
	assign den_out = d_q;
endmodule

/* rtl/rational_arithmetic_unit_top.sv */
// Each word runs through up to three reductions, each a Euclidean gcd and two divisions by it on
// the shared divider, then one final division that splits off the whole part; the number of gcd
// steps depends on the data.
// Throughput: one word at a time; the shared radix-2 divider sets the pace.
// The output register holds a result until taken; a new word is taken after that.
// Reset is asynchronous, active low, and clears the sequencer and the valid flags.
module rational_arithmetic_unit_top import rau_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_word_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_word_t out_data
);
`include "rational_arithmetic_unit_top_assert.svh"
	state_t st_q;
	in_word_t in_q;
	logic signed [63:0] an_q, ad_q, bn_q, bd_q, p1_q, p2_q, rn_q, rd_q;
	logic red_start, red_done;
	logic [63:0] red_nmag, red_den, red_nout, red_dout;
	logic neg_q;
	div_req_t red_req, req;
	div_rsp_t rsp;
	logic split_issue_q, split_wait_q;
	logic signed [31:0] ma, mb;
	logic signed [63:0] mp;
	logic bad;
	out_word_t out_q;
	logic sel_neg;
	logic signed [63:0] sel_n, sel_d;

	rau_divider u_div (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));
	rau_reducer u_red (.clk(clk), .arst_n(arst_n), .start(red_start), .num_mag(red_nmag),
		.den(red_den), .rsp(rsp), .req(red_req), .done(red_done), .num_out(red_nout),
		.den_out(red_dout));

	always_comb begin
		req = red_req;
		if (st_q == S_SPLIT) begin
			req.start = split_issue_q;
			req.a = rn_q[63] ? -rn_q : rn_q;
			req.b = rd_q;
		end
	end

	always_comb begin
		sel_n = an_q;
		sel_d = ad_q;
		if (st_q == S_RED_B) begin
			sel_n = bn_q;
			sel_d = bd_q;
		end else if (st_q == S_RED_R) begin
			sel_n = rn_q;
			sel_d = rd_q;
		end
		sel_neg = sel_n[63] ^ sel_d[63];
		red_nmag = sel_n[63] ? -sel_n : sel_n;
		red_den = sel_d[63] ? -sel_d : sel_d;
	end

	always_comb begin
		ma = an_q[31:0];
		mb = bd_q[31:0];
		case (st_q)
			S_MUL1: begin
				ma = an_q[31:0];
				mb = (in_q.operation == OP_MUL) ? bn_q[31:0] : bd_q[31:0];
			end
			S_MUL2: begin
				ma = bn_q[31:0];
				mb = ad_q[31:0];
			end
			S_MUL3: begin
				ma = ad_q[31:0];
				mb = (in_q.operation == OP_DIV) ? bn_q[31:0] : bd_q[31:0];
			end
			default: ;
		endcase
		mp = ma * mb;
	end

	assign bad = (in_q.a_den == '0) || (in_q.b_den == '0) || (in_q.a_num == 32'sh80000000)
		|| (in_q.a_den == 32'sh80000000) || (in_q.b_num == 32'sh80000000)
		|| (in_q.b_den == 32'sh80000000);

	assign in_stall = (st_q != S_IDLE);
	assign out_valid = (st_q == S_OUT);
	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			red_start <= 1'b0;
			split_issue_q <= 1'b0;
			split_wait_q <= 1'b0;
		end else begin
			red_start <= 1'b0;
			split_issue_q <= 1'b0;
			case (st_q)
				S_IDLE: if (in_valid) st_q <= S_CHECK;
				S_CHECK: begin
					if (bad) st_q <= S_OUT;
					else begin
						st_q <= S_RED_A;
						red_start <= 1'b1;
					end
				end
				S_RED_A: if (red_done) begin
					st_q <= S_RED_B;
					red_start <= 1'b1;
				end
				S_RED_B: if (red_done) begin
					if (in_q.operation == OP_DIV && bn_q == '0) st_q <= S_OUT;
					else st_q <= S_MUL1;
				end
				S_MUL1: st_q <= S_MUL2;
				S_MUL2: st_q <= S_MUL3;
				S_MUL3: st_q <= S_COMBINE;
				S_COMBINE: begin
					st_q <= S_RED_R;
					red_start <= 1'b1;
				end
				S_RED_R: if (red_done) begin
					st_q <= S_SPLIT;
					split_issue_q <= 1'b1;
					split_wait_q <= 1'b1;
				end
				S_SPLIT: if (split_wait_q && rsp.done) begin
					split_wait_q <= 1'b0;
					st_q <= S_OUT;
				end
				S_OUT: if (!out_stall) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: if (in_valid) in_q <= in_data;
			S_CHECK: begin
				an_q <= 64'(in_q.a_num);
				ad_q <= 64'(in_q.a_den);
				bn_q <= 64'(in_q.b_num);
				bd_q <= 64'(in_q.b_den);
				out_q <= '{result_num: '0, result_den: '0, status: ST_INVALID,
					whole_part: '0, remainder: '0, negative: 1'b0};
			end
			S_RED_A: if (red_done) begin
				an_q <= neg_q ? -red_nout : red_nout;
				ad_q <= red_dout;
			end
			S_RED_B: if (red_done) begin
				bn_q <= neg_q ? -red_nout : red_nout;
				bd_q <= red_dout;
				out_q <= '{result_num: 64'sd1, result_den: '0, status: ST_INF,
					whole_part: '0, remainder: '0, negative: 1'b0};
			end
			S_MUL1: p1_q <= mp;
			S_MUL2: p2_q <= mp;
			S_MUL3: rd_q <= mp;
			S_COMBINE: begin
				case (in_q.operation)
					OP_ADD: rn_q <= p1_q + p2_q;
					OP_SUB: rn_q <= p1_q - p2_q;
					default: rn_q <= p1_q;
				endcase
			end
			S_RED_R: if (red_done) begin
				rn_q <= neg_q ? -red_nout : red_nout;
				rd_q <= red_dout;
			end
			S_SPLIT: if (split_wait_q && rsp.done) begin
				out_q <= '{result_num: rn_q, result_den: rd_q[62:0], status: ST_OK,
					whole_part: rsp.quo[62:0], remainder: rsp.rem[61:0],
					negative: rn_q[63]};
			end
			default: ;
		endcase
		if (red_start) neg_q <= sel_neg;
	end

	`RAU_ASSERT_IMP(a_stall_busy, out_valid, in_stall)
	`RAU_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
	`RAU_ASSERT_IMP(a_ok_den, out_valid && out_data.status == ST_OK, out_data.result_den != '0)
endmodule
